FILE: sv/pia_pkg.sv
// Shared constants, types and helper functions for the ARGB4444 palette indexer.
package pia_pkg;

   // Number of palette slots, one cell of the match chain per slot.
   localparam int MAX_COLORS = 16;
   // Width of a palette index and of the entry counter.
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;
   localparam int PIX_W = 32;
   localparam int ARGB_W = 16;
   localparam int BYTE_W = 8;

   // Reset value of the palette limit register.
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_COLORS);

   // Token that walks down the chain of match cells with one request.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic [PIX_W-1:0] pixel;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] limit;
      logic             found;
      logic [IDX_W-1:0] idx;
      logic             is_new;
   } token_type;

   // Top nibble of each 8-bit channel, arranged as alpha, red, green, blue.
   function automatic logic [ARGB_W-1:0] to_argb4444(input logic [PIX_W-1:0] p);
      to_argb4444 = {p[31:28], p[7:4], p[15:12], p[23:20]};
   endfunction

endpackage

FILE: sv/pia_if.sv
// Request and response channel interfaces of the palette indexer.
interface pia_req_if;
   logic        valid;
   logic        ready;
   logic        first_pixel;
   logic [31:0] pixel_word;

   modport source (output valid, output first_pixel, output pixel_word, input ready);
   modport sink (input valid, input first_pixel, input pixel_word, output ready);
endinterface

interface pia_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  color_index;
   logic        new_color;
   logic [15:0] argb4444;
   logic        overflow;
   logic [7:0]  packed_byte;
   logic        byte_ready;

   modport source (output valid, output color_index, output new_color, output argb4444,
                   output overflow, output packed_byte, output byte_ready, input ready);
   modport sink (input valid, input color_index, input new_color, input argb4444,
                 input overflow, input packed_byte, input byte_ready, output ready);
endinterface

FILE: sv/palette_indexer_argb4444_top.sv
// Top level of the exact-match 4-bit palette indexer with ARGB4444 output.
//
// Usage:
//   req_if carries one pixel per request: first_pixel and the 32-bit RGBA word
//   (red in the low byte, alpha in the top byte). first_pixel starts a new image
//   and clears the palette, the entry count, the nibble parity and the overflow flag.
//   rsp_if returns one response per request: the palette index, the new-entry flag
//   with its ARGB4444 word, the sticky overflow flag and the packed index byte, which
//   is complete on every odd pixel. csr_we/csr_wdata write the palette limit (reset
//   16, saturated at 16) while idle: a rule for the user, not enforced by the block.
//
// Timing:
//   A request walks a chain of 16 match cells, one cell per cycle while the chain
//   advances, and then lands in the response register. One request is in flight at a
//   time: req_if.ready stays low from acceptance until the response register has taken
//   the result. If the receiver stalls, the token waits at the chain tail until then.
//   Reset empties the chain and the response register and clears all image state.
module palette_indexer_argb4444_top (
   input  logic                      clock,
   input  logic                      reset,
   pia_req_if.sink                   req_if,
   pia_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [pia_pkg::CNT_W-1:0] csr_wdata
);
   import pia_pkg::*;

   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             parity_ff;
   logic [IDX_W-1:0] high_ff;
   logic             overflow_ff;
   logic             busy_ff;
   logic             rsp_valid_ff;

   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_new_ff;
   logic [ARGB_W-1:0] rsp_argb_ff;
   logic              rsp_ovf_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_ready_ff;

   token_type        chain [0:MAX_COLORS];
   token_type        head;
   token_type        tail;
   logic             accept;
   logic             load;
   logic             advance;
   logic [CNT_W-1:0] eff_limit;

   logic             base_parity;
   logic [IDX_W-1:0] base_high;
   logic             base_ovf;
   logic [IDX_W-1:0] fin_idx;
   logic             fin_ovf;

   // Handshake and chain flow control.
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = !busy_ff;
   assign tail = chain[MAX_COLORS];
   assign load = tail.valid && (!rsp_valid_ff || rsp_if.ready);
   assign advance = !tail.valid || load;

   // Effective limit saturates at the table size.
   assign eff_limit = (limit_ff > MAX_COUNT) ? MAX_COUNT : limit_ff;

   // Token injected into the first cell.
   always_comb begin
      head = '0;
      head.valid = accept;
      head.first = req_if.first_pixel;
      head.pixel = req_if.pixel_word;
      head.count = req_if.first_pixel ? '0 : count_ff;
      head.limit = eff_limit;
   end

   assign chain[0] = head;

   // Row of match cells.
   for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
      pia_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (IDX_W'(i)),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   // Result of the token at the tail, with first_pixel applied to the image state.
   assign base_parity = tail.first ? 1'b0 : parity_ff;
   assign base_high = tail.first ? '0 : high_ff;
   assign base_ovf = tail.first ? 1'b0 : overflow_ff;
   assign fin_idx = tail.found ? tail.idx : '0;
   assign fin_ovf = base_ovf || !tail.found;
   assign count_in = tail.is_new ? tail.count + CNT_W'(1) : tail.count;

   // Limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Busy set on accept; image state and busy updated as the response register loads.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         parity_ff <= 1'b0;
         high_ff <= '0;
         overflow_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end
         if (load) begin
            busy_ff <= 1'b0;
            count_ff <= count_in;
            parity_ff <= !base_parity;
            if (!base_parity) begin
               high_ff <= fin_idx;
            end else begin
               high_ff <= base_high;
            end
            overflow_ff <= fin_ovf;
         end
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_idx_ff <= fin_idx;
         rsp_new_ff <= tail.is_new;
         rsp_argb_ff <= tail.is_new ? to_argb4444(tail.pixel) : '0;
         rsp_ovf_ff <= fin_ovf;
         rsp_ready_ff <= base_parity;
         if (base_parity) begin
            rsp_byte_ff <= {base_high, fin_idx};
         end else begin
            rsp_byte_ff <= {fin_idx, {IDX_W{1'b0}}};
         end
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.color_index = rsp_idx_ff;
   assign rsp_if.new_color = rsp_new_ff;
   assign rsp_if.argb4444 = rsp_argb_ff;
   assign rsp_if.overflow = rsp_ovf_ff;
   assign rsp_if.packed_byte = rsp_byte_ff;
   assign rsp_if.byte_ready = rsp_ready_ff;

   // An idle block holds no token at the chain tail.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !tail.valid)
      else $error("token at chain tail while idle");

   // The entry count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("palette count beyond table size");

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("request accepted without going busy");

   // A stalled tail token must not be overwritten by the chain.
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !load) |=> (tail.valid && $stable(tail.pixel)))
      else $error("stalled tail token lost");

endmodule

FILE: sv/pia_cell.sv
// One palette slot: holds a stored color, matches or claims it, and forwards the token.
module pia_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [pia_pkg::IDX_W-1:0] cell_idx,
   input  pia_pkg::token_type       tok_in,
   output pia_pkg::token_type       tok_out
);
   import pia_pkg::*;

   logic [PIX_W-1:0] entry_ff;
   token_type        token_ff;
   token_type        token_in;
   logic [CNT_W-1:0] my_slot;
   logic             hit;
   logic             claim;

   assign my_slot = {1'b0, cell_idx};

   // Slots below the count are live and are compared; the first free slot may be claimed.
   assign hit = tok_in.valid && !tok_in.found && (my_slot < tok_in.count)
                && (entry_ff == tok_in.pixel);
   assign claim = tok_in.valid && !tok_in.found && (my_slot == tok_in.count)
                  && (tok_in.count < tok_in.limit);

   always_comb begin
      token_in = tok_in;
      if (hit || claim) begin
         token_in.found = 1'b1;
         token_in.idx = cell_idx;
      end
      if (claim) begin
         token_in.is_new = 1'b1;
      end
   end

   // Stored color is written only when this slot is claimed.
   always_ff @(posedge clock) begin
      if (advance && claim) begin
         entry_ff <= tok_in.pixel;
      end
   end

   // Token register toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_in;
      end
   end

   assign tok_out = token_ff;

endmodule

FILE: sim/palette_indexer_argb4444_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ARGB4444 palette indexer top level.
module palette_indexer_argb4444_top_tb;

   localparam int PALETTE_SLOTS = pia_pkg::MAX_COLORS;
   localparam int STALL_LIMIT = 2000;
   localparam int SHOWN_MISMATCHES = 10;

   // One expected response: index, new-entry data, overflow flag, packed byte and byte-ready flag.
   typedef struct packed {
      logic [pia_pkg::IDX_W-1:0]  color_index;
      logic                       new_color;
      logic [pia_pkg::ARGB_W-1:0] argb4444;
      logic                       overflow;
      logic [pia_pkg::BYTE_W-1:0] packed_byte;
      logic                       byte_ready;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [pia_pkg::CNT_W-1:0] csr_wdata;

   pia_req_if req_bus ();
   pia_rsp_if rsp_bus ();

   palette_indexer_argb4444_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predicted palette state of the current image.
   logic [pia_pkg::PIX_W-1:0] pal_colors [PALETTE_SLOTS];
   logic [pia_pkg::CNT_W-1:0] pal_count;
   logic                      pal_parity;
   logic [pia_pkg::IDX_W-1:0] pal_high_nibble;
   logic                      pal_overflow;
   logic [pia_pkg::CNT_W-1:0] pal_limit;

   lookup_result_type pending_lookups [$];
   int mismatch_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_cycles = 0;

   // Random image generation state, kept across phases so images span limit changes.
   logic [pia_pkg::PIX_W-1:0] color_pool [$];
   int image_left = 0;

   always #5 clock = ~clock;

   // Receiver: holds off responses at the current stall rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: ends the run when nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.color_index = rsp_bus.color_index;
         got.new_color = rsp_bus.new_color;
         got.argb4444 = rsp_bus.argb4444;
         got.overflow = rsp_bus.overflow;
         got.packed_byte = rsp_bus.packed_byte;
         got.byte_ready = rsp_bus.byte_ready;
         if (pending_lookups.size() == 0) begin
            note_mismatch($sformatf("unexpected response idx=%0d new=%0b argb=%h",
                                    got.color_index, got.new_color, got.argb4444));
         end else begin
            want = pending_lookups.pop_front();
            if (got.color_index !== want.color_index || got.new_color !== want.new_color ||
                got.argb4444 !== want.argb4444 || got.overflow !== want.overflow ||
                got.packed_byte !== want.packed_byte ||
                got.byte_ready !== want.byte_ready) begin
               note_mismatch({
                  $sformatf("exp idx=%0d new=%0b argb=%h ovf=%0b byte=%h rdy=%0b",
                            want.color_index, want.new_color, want.argb4444,
                            want.overflow, want.packed_byte, want.byte_ready),
                  $sformatf(", got idx=%0d new=%0b argb=%h ovf=%0b byte=%h rdy=%0b",
                            got.color_index, got.new_color, got.argb4444,
                            got.overflow, got.packed_byte, got.byte_ready)});
            end
         end
      end
   end

   task automatic clear_palette();
      foreach (pal_colors[i]) pal_colors[i] = '0;
      pal_count = '0;
      pal_parity = 1'b0;
      pal_high_nibble = '0;
      pal_overflow = 1'b0;
   endtask

   // Works out the response to one accepted pixel and queues it.
   task automatic predict_lookup(input logic new_image, input logic [pia_pkg::PIX_W-1:0] pix);
      lookup_result_type res;
      int eff_limit;
      logic found;
      res = '0;
      found = 1'b0;
      if (new_image) clear_palette();
      eff_limit = (pal_limit > PALETTE_SLOTS) ? PALETTE_SLOTS : int'(pal_limit);

      // Exact match against the stored entries only.
      for (int i = 0; i < pal_count; i++) begin
         if (!found && pal_colors[i] == pix) begin
            found = 1'b1;
            res.color_index = i[pia_pkg::IDX_W-1:0];
         end
      end

      // Append a new colour, or flag overflow when the table is at its limit.
      if (!found) begin
         if (pal_count < eff_limit) begin
            res.color_index = pal_count[pia_pkg::IDX_W-1:0];
            pal_colors[pal_count] = pix;
            pal_count = pal_count + 1'b1;
            res.new_color = 1'b1;
            res.argb4444 = {pix[31:28], pix[7:4], pix[15:12], pix[23:20]};
         end else begin
            pal_overflow = 1'b1;
            res.color_index = '0;
         end
      end

      // Two indices per byte, the even pixel in the high nibble.
      if (!pal_parity) begin
         pal_high_nibble = res.color_index;
         res.packed_byte = {res.color_index, 4'h0};
         res.byte_ready = 1'b0;
         pal_parity = 1'b1;
      end else begin
         res.packed_byte = {pal_high_nibble, res.color_index};
         res.byte_ready = 1'b1;
         pal_parity = 1'b0;
      end
      res.overflow = pal_overflow;
      pending_lookups.push_back(res);
   endtask

   // Sends one pixel request, with an optional idle gap ahead of it.
   task automatic send_pixel(input logic new_image, input logic [pia_pkg::PIX_W-1:0] pix);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.first_pixel <= new_image;
      req_bus.pixel_word <= pix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_lookup(new_image, pix);
   endtask

   // Waits until every expected response has arrived and the block is idle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [pia_pkg::CNT_W-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pal_limit = value;
   endtask

   // Fills all sixteen slots at the reset limit, overflows, then hits the last slot.
   task automatic test_palette_fill();
      logic [pia_pkg::PIX_W-1:0] fill_colors [PALETTE_SLOTS] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000,
         32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h8000_0000, 32'h0000_0001,
         32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFE, 32'h7FFF_FFFF};
      foreach (fill_colors[i]) send_pixel(i == 0, fill_colors[i]);
      send_pixel(1'b0, 32'hDEAD_BEEF);
      send_pixel(1'b0, 32'h7FFF_FFFF);
   endtask

   // A limit of zero admits nothing, so the first pixel already overflows.
   task automatic test_zero_limit();
      write_limit(5'd0);
      send_pixel(1'b1, 32'hC0FF_EE00);
   endtask

   // One slot: a near-miss colour overflows and the stored one keeps index 0.
   task automatic test_single_entry();
      write_limit(5'd1);
      send_pixel(1'b1, 32'h1234_5678);
      send_pixel(1'b0, 32'h1234_5679);
      send_pixel(1'b0, 32'h1234_5678);
   endtask

   // A saturating limit, then a lower limit in the middle of an image.
   task automatic test_limit_lowered();
      write_limit(5'd31);
      send_pixel(1'b1, 32'hA1B2_C3D4);
      send_pixel(1'b0, 32'h4D3C_2B1A);
      write_limit(5'd1);
      send_pixel(1'b0, 32'h0102_0304);
      send_pixel(1'b0, 32'h4D3C_2B1A);
   endtask

   // Random images built from small colour pools, with limit changes along the way.
   task automatic test_random_images(input int n_items, input int idle_pct, input int stall_pct);
      int items_to_write;
      int pick;
      logic new_image;
      logic [pia_pkg::PIX_W-1:0] pix;
      logic [pia_pkg::CNT_W-1:0] limit_value;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      items_to_write = $urandom_range(60, 140);
      for (int n = 0; n < n_items; n++) begin
         if (items_to_write == 0) begin
            case ($urandom_range(7))
               0: limit_value = 5'd0;
               1: limit_value = 5'd1;
               2: limit_value = 5'd16;
               3: limit_value = 5'd31;
               4: limit_value = 5'd2;
               5: limit_value = 5'($urandom_range(17, 31));
               default: limit_value = 5'($urandom_range(1, 16));
            endcase
            write_limit(limit_value);
            items_to_write = $urandom_range(60, 140);
         end
         items_to_write--;

         // New image with a fresh pool; some pools hold colours one bit apart.
         new_image = 1'b0;
         if (image_left == 0) begin
            new_image = 1'b1;
            image_left = $urandom_range(1, 48);
            color_pool.delete();
            repeat ($urandom_range(1, 20)) begin
               if (color_pool.size() > 0 && $urandom_range(99) < 25) begin
                  color_pool.push_back(color_pool[$urandom_range(color_pool.size() - 1)] ^
                                       (32'h1 << $urandom_range(31)));
               end else begin
                  color_pool.push_back($urandom);
               end
            end
         end else if ($urandom_range(99) < 2) begin
            // Restart in the middle of an image, keeping the same pool.
            new_image = 1'b1;
         end
         image_left--;

         pick = $urandom_range(99);
         if (pick < 85) begin
            pix = color_pool[$urandom_range(color_pool.size() - 1)];
         end else if (pick < 95) begin
            pix = $urandom;
         end else begin
            pix = pick[0] ? '1 : '0;
         end
         send_pixel(new_image, pix);
      end
   endtask

   // Test sequence.
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.first_pixel <= 1'b0;
      req_bus.pixel_word <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      clear_palette();
      pal_limit = pia_pkg::LIMIT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 34;
      rsp_stall_pct = 62;
      test_palette_fill();
      test_zero_limit();
      test_single_entry();
      test_limit_lowered();

      test_random_images(433, 34, 62);
      test_random_images(433, 62, 34);
      test_random_images(434, 0, 0);

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: palette_indexer_argb4444_top.f
sv/pia_pkg.sv
sv/pia_if.sv
sv/pia_cell.sv
sv/palette_indexer_argb4444_top.sv
sim/palette_indexer_argb4444_top_tb.sv
